>>> src/clamped_row_sample_address_gen_macros.svh
// assertion macros of the address generator module
`ifndef CLAMPED_ROW_SAMPLE_ADDRESS_GEN_MACROS_SVH
`define CLAMPED_ROW_SAMPLE_ADDRESS_GEN_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRSAG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("address generator check failed");

// next-cycle implication, disabled during reset
`define CRSAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("address generator check failed");

`endif

>>> src/crsag_pkg.sv
// ----------------------------------------------------------------------------
// crsag_pkg
// shared types and constants of the clamped row sample address generator
// ----------------------------------------------------------------------------
package crsag_pkg;

   // largest image dimension honored by the clamp
   localparam int MAX_DIM = 4096;
   // one whole pixel in fraction units
   localparam int FRAC_ONE = 65535;

   localparam int POS_W   = 24;
   localparam int FRAC_W  = 22;
   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;

   // item action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   // register indexes
   localparam logic [2:0] REG_X_STEP      = 3'd0;
   localparam logic [2:0] REG_Y_STEP      = 3'd1;
   localparam logic [2:0] REG_X_FRAC_STEP = 3'd2;
   localparam logic [2:0] REG_Y_FRAC_STEP = 3'd3;
   localparam logic [2:0] REG_IMAGE_W     = 3'd4;
   localparam logic [2:0] REG_IMAGE_H     = 3'd5;

   typedef struct packed {
      logic signed [11:0] x_step;
      logic signed [11:0] y_step;
      logic signed [20:0] x_frac_step;
      logic signed [20:0] y_frac_step;
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
   } cfg_type;

endpackage

>>> src/clamped_row_sample_address_gen.sv
// ----------------------------------------------------------------------------
// clamped_row_sample_address_gen
// nearest-neighbor source address generator for one resampled row
// ----------------------------------------------------------------------------
// A load item (action 0) sets the row start position and length and returns
// nothing; each step item (action 1) returns one clamped source coordinate
// pair with an alpha-zero flag and a last-of-row mark, then advances by the
// configured increments. Steps after the row is done are dropped. Items are
// taken one per clock while the result slot is free (req_stall holds them
// otherwise): an item is captured in an input register, and once the result
// slot is free the normalize, clamp and advance logic updates the row state
// and loads the result register, from which the result is taken. The row
// state update is the loop that sets the one-item-per-clock rate.
// Configuration registers are written through the apb-style port; the user
// must write them only while no item is in flight, the block does not enforce it.
module clamped_row_sample_address_gen (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_action,
   input  logic [15:0]  req_start_x,
   input  logic [15:0]  req_start_y,
   input  logic [15:0]  req_start_frac_x,
   input  logic [15:0]  req_start_frac_y,
   input  logic [12:0]  req_row_length,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [11:0]  rsp_read_x,
   output logic [11:0]  rsp_read_y,
   output logic         rsp_alpha_zero,
   output logic         rsp_last_in_row,
   // configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [4:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

`include "clamped_row_sample_address_gen_macros.svh"

   crsag_pkg::cfg_type cfg;

   // input register
   logic         in_vld_ff,  in_vld_in;
   logic         in_action_ff;
   logic [15:0]  in_start_x_ff, in_start_y_ff;
   logic [15:0]  in_frac_x_ff, in_frac_y_ff;
   logic [12:0]  in_length_ff;

   // row state
   logic signed [crsag_pkg::POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [crsag_pkg::FRAC_W-1:0] frac_x_ff, frac_x_in, frac_y_ff, frac_y_in;
   logic [crsag_pkg::DIM_W-1:0]         left_ff, left_in;

   // result register
   logic         out_vld_ff, out_vld_in;
   logic [11:0]  out_x_ff, out_y_ff;
   logic         out_alpha_ff, out_last_ff;

   logic         out_free, process, accept, emit, last_pix;
   logic signed [crsag_pkg::POS_W-1:0]  norm_pos_x, norm_pos_y;
   logic signed [crsag_pkg::FRAC_W-1:0] norm_frac_x, norm_frac_y;
   logic [11:0]  clamp_x, clamp_y;
   logic         clamped_x, clamped_y;

   crsag_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: the input register drains whenever the result slot is free
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign process   = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign emit      = process && (in_action_ff == crsag_pkg::ACT_STEP) && (left_ff != '0);
   assign last_pix  = left_ff == crsag_pkg::DIM_W'(1);

   always_comb begin
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (process) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff  <= req_action;
         in_start_x_ff <= req_start_x;
         in_start_y_ff <= req_start_y;
         in_frac_x_ff  <= req_start_frac_x;
         in_frac_y_ff  <= req_start_frac_y;
         in_length_ff  <= req_row_length;
      end
   end

   // normalize both axes
   crsag_norm u_norm_x (
      .pos      (pos_x_ff),
      .frac     (frac_x_ff),
      .pos_out  (norm_pos_x),
      .frac_out (norm_frac_x)
   );

   crsag_norm u_norm_y (
      .pos      (pos_y_ff),
      .frac     (frac_y_ff),
      .pos_out  (norm_pos_y),
      .frac_out (norm_frac_y)
   );

   // clamp both axes into the image
   crsag_clamp u_clamp_x (
      .pos     (norm_pos_x),
      .size    (cfg.image_width),
      .coord   (clamp_x),
      .clamped (clamped_x)
   );

   crsag_clamp u_clamp_y (
      .pos     (norm_pos_y),
      .size    (cfg.image_height),
      .coord   (clamp_y),
      .clamped (clamped_y)
   );

   // row state update: load, or advance after a step
   always_comb begin
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      frac_x_in = frac_x_ff;
      frac_y_in = frac_y_ff;
      left_in   = left_ff;
      if (process && (in_action_ff == crsag_pkg::ACT_LOAD)) begin
         pos_x_in  = crsag_pkg::POS_W'($signed(in_start_x_ff));
         pos_y_in  = crsag_pkg::POS_W'($signed(in_start_y_ff));
         frac_x_in = $signed(crsag_pkg::FRAC_W'(in_frac_x_ff));
         frac_y_in = $signed(crsag_pkg::FRAC_W'(in_frac_y_ff));
         left_in   = in_length_ff;
      end else if (emit) begin
         pos_x_in  = norm_pos_x + crsag_pkg::POS_W'(cfg.x_step);
         pos_y_in  = norm_pos_y + crsag_pkg::POS_W'(cfg.y_step);
         frac_x_in = norm_frac_x + crsag_pkg::FRAC_W'(cfg.x_frac_step);
         frac_y_in = norm_frac_y + crsag_pkg::FRAC_W'(cfg.y_frac_step);
         left_in   = left_ff - crsag_pkg::DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         frac_x_ff <= '0;
         frac_y_ff <= '0;
         left_ff   <= '0;
      end else begin
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         frac_x_ff <= frac_x_in;
         frac_y_ff <= frac_y_in;
         left_ff   <= left_in;
      end
   end

   // result register
   always_comb begin
      if (emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_stall) begin
         out_vld_in = out_vld_ff;
      end else begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_x_ff     <= clamp_x;
         out_y_ff     <= clamp_y;
         out_alpha_ff <= clamped_x || clamped_y;
         out_last_ff  <= last_pix;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_read_x      = out_x_ff;
   assign rsp_read_y      = out_y_ff;
   assign rsp_alpha_zero  = out_alpha_ff;
   assign rsp_last_in_row = out_last_ff;

   // checks
   `CRSAG_ASSERT_NEXT(a_held_item_kept, clock, reset, in_vld_ff && !out_free, in_vld_ff)
   `CRSAG_ASSERT_NEXT(a_last_empties_row, clock, reset, emit && last_pix, left_ff == '0)
   `CRSAG_ASSERT_NEXT(a_step_counts_down, clock, reset, emit,
                      left_ff == $past(left_ff) - crsag_pkg::DIM_W'(1))
   `CRSAG_ASSERT_IMPLY(a_norm_frac_range, clock, reset, emit,
                       norm_frac_x[crsag_pkg::FRAC_W-1:16] == '0
                       && norm_frac_y[crsag_pkg::FRAC_W-1:16] == '0)

endmodule

>>> src/crsag_csr.sv
// ----------------------------------------------------------------------------
// crsag_csr
// configuration register file behind a simple apb-style port
// ----------------------------------------------------------------------------
module crsag_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output crsag_pkg::cfg_type  cfg
);

   crsag_pkg::cfg_type cfg_ff;
   crsag_pkg::cfg_type cfg_in;
   logic [2:0]         reg_idx;
   logic               wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            crsag_pkg::REG_X_STEP:      cfg_in.x_step      = pwdata[11:0];
            crsag_pkg::REG_Y_STEP:      cfg_in.y_step      = pwdata[11:0];
            crsag_pkg::REG_X_FRAC_STEP: cfg_in.x_frac_step = pwdata[20:0];
            crsag_pkg::REG_Y_FRAC_STEP: cfg_in.y_frac_step = pwdata[20:0];
            crsag_pkg::REG_IMAGE_W:     cfg_in.image_width  = pwdata[12:0];
            crsag_pkg::REG_IMAGE_H:     cfg_in.image_height = pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_step       <= 12'sd1;
         cfg_ff.y_step       <= 12'sd0;
         cfg_ff.x_frac_step  <= 21'sd0;
         cfg_ff.y_frac_step  <= 21'sd0;
         cfg_ff.image_width  <= 13'd256;
         cfg_ff.image_height <= 13'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read decode
   always_comb begin
      unique case (reg_idx)
         crsag_pkg::REG_X_STEP:      prdata = {20'd0, cfg_ff.x_step};
         crsag_pkg::REG_Y_STEP:      prdata = {20'd0, cfg_ff.y_step};
         crsag_pkg::REG_X_FRAC_STEP: prdata = {11'd0, cfg_ff.x_frac_step};
         crsag_pkg::REG_Y_FRAC_STEP: prdata = {11'd0, cfg_ff.y_frac_step};
         crsag_pkg::REG_IMAGE_W:     prdata = {19'd0, cfg_ff.image_width};
         crsag_pkg::REG_IMAGE_H:     prdata = {19'd0, cfg_ff.image_height};
         default:                    prdata = 32'd0;
      endcase
   end

endmodule

>>> src/crsag_norm.sv
// ----------------------------------------------------------------------------
// crsag_norm
// moves whole pixels out of the fraction so it ends up in 0..65534
// (an exact negative multiple borrows one extra and leaves 65535)
// ----------------------------------------------------------------------------
module crsag_norm (
   input  logic signed [crsag_pkg::POS_W-1:0]  pos,
   input  logic signed [crsag_pkg::FRAC_W-1:0] frac,
   output logic signed [crsag_pkg::POS_W-1:0]  pos_out,
   output logic signed [crsag_pkg::FRAC_W-1:0] frac_out
);

   logic                             neg;
   logic [crsag_pkg::FRAC_W-1:0]     mag;
   logic [5:0]                       mag_hi;
   logic [15:0]                      mag_lo;
   logic [16:0]                      part_sum;
   logic                             wrap;
   logic [6:0]                       quot;
   logic [15:0]                      rem;
   logic [crsag_pkg::POS_W-1:0]      delta;

   assign neg = frac[crsag_pkg::FRAC_W-1];
   assign mag = neg ? crsag_pkg::FRAC_W'(-frac) : crsag_pkg::FRAC_W'(frac);

   // divide by 2^16-1: m = hi*65536 + lo = hi*65535 + (hi + lo)
   assign mag_hi   = mag[21:16];
   assign mag_lo   = mag[15:0];
   assign part_sum = 17'(mag_hi) + 17'(mag_lo);
   assign wrap     = part_sum >= 17'(crsag_pkg::FRAC_ONE);
   assign quot     = 7'(mag_hi) + 7'(wrap);
   assign rem      = wrap ? 16'(part_sum - 17'(crsag_pkg::FRAC_ONE)) : part_sum[15:0];

   // borrow is -(q+1), which is the complement of q
   assign delta   = neg ? ~crsag_pkg::POS_W'(quot) : crsag_pkg::POS_W'(quot);
   assign pos_out = pos + $signed(delta);

   assign frac_out = neg ? $signed(crsag_pkg::FRAC_W'(17'(crsag_pkg::FRAC_ONE) - 17'(rem)))
                         : $signed(crsag_pkg::FRAC_W'(rem));

endmodule

>>> src/crsag_clamp.sv
// ----------------------------------------------------------------------------
// crsag_clamp
// clamps one axis position into the image and flags when it had to
// ----------------------------------------------------------------------------
module crsag_clamp (
   input  logic signed [crsag_pkg::POS_W-1:0] pos,
   input  logic [crsag_pkg::DIM_W-1:0]        size,
   output logic [crsag_pkg::COORD_W-1:0]      coord,
   output logic                               clamped
);

   logic                          over_cap;
   logic [crsag_pkg::DIM_W-1:0]   eff_size;
   logic [crsag_pkg::DIM_W-1:0]   limit;
   logic                          below;
   logic                          above;

   // zero size counts as one, large sizes are capped
   assign over_cap = 32'(size) > crsag_pkg::MAX_DIM;
   always_comb begin
      if (size == '0) begin
         eff_size = crsag_pkg::DIM_W'(1);
      end else if (over_cap) begin
         eff_size = crsag_pkg::DIM_W'(crsag_pkg::MAX_DIM);
      end else begin
         eff_size = size;
      end
   end

   assign limit = eff_size - crsag_pkg::DIM_W'(1);
   assign below = pos[crsag_pkg::POS_W-1];
   assign above = !below && (pos[crsag_pkg::POS_W-2:0] >= (crsag_pkg::POS_W-1)'(eff_size));

   // select clamped coordinate
   always_comb begin
      if (below) begin
         coord = '0;
      end else if (above) begin
         coord = limit[crsag_pkg::COORD_W-1:0];
      end else begin
         coord = pos[crsag_pkg::COORD_W-1:0];
      end
   end

   assign clamped = below || above;

endmodule
